[hw/rtl/assert_macros.svh]
// Assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge out of reset
`define CBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a consequence holds in the cycle after its trigger
`define CBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cbp_pkg.sv]
package cbp_pkg;

    localparam int GAIN_W   = 16;
    localparam int DATA_W   = 16;
    localparam int OUT_W    = 14;
    localparam int INT_W    = 12;
    localparam int DZ_W     = 13;
    localparam int FRAC     = 8;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;

    localparam logic [1:0] MODE_SPEED  = 2'd0;
    localparam logic [1:0] MODE_ANGLE  = 2'd1;
    localparam logic [1:0] MODE_GYRO   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] REG_SPEED_KP  = 3'd0;
    localparam logic [2:0] REG_SPEED_KI  = 3'd1;
    localparam logic [2:0] REG_ANGLE_KP  = 3'd2;
    localparam logic [2:0] REG_ANGLE_KD  = 3'd3;
    localparam logic [2:0] REG_GYRO_KP   = 3'd4;
    localparam logic [2:0] REG_GYRO_KD   = 3'd5;
    localparam logic [2:0] REG_ZERO_OFS  = 3'd6;
    localparam logic [2:0] REG_DEAD_ZONE = 3'd7;

    localparam logic signed [INT_W-1:0] SPEED_INT_LIMIT = 12'sd2000;
    localparam logic signed [OUT_W-1:0] SPEED_OUT_LIMIT = 14'sd1500;
    localparam logic signed [OUT_W-1:0] ANGLE_OUT_LIMIT = 14'sd8000;
    localparam logic signed [OUT_W-1:0] GYRO_OUT_LIMIT  = 14'sd6000;

endpackage

[hw/rtl/cascaded_balance_pid.sv]
// Channel    Dir  Handshake            Payload
// s stream   in   i_s_tvalid/o_s_tready mode, reference, measured
// m stream   out  o_m_tvalid/i_m_tready loop_mode, loop_out
// APB        in   psel/penable/pready   eight gain, offset and dead-zone registers
//
// One item per cycle sustained while the output is not stalled.
// A single multiply-add-clamp pass lies between the input register
// and the result register.
// Synchronous active-low reset clears registers, loop state and both stages.
// A stalled result holds; o_s_tready drops only when both stages are full.
`include "assert_macros.svh"

module cascaded_balance_pid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] reference, [31:16] measured
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [13:0] loop_out, [15:14] zero
    output logic [1:0]  o_m_tuser,   // [1:0] loop_mode
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [cbp_pkg::ADDR_W-1:0] paddr,
    input  logic [cbp_pkg::APB_W-1:0]  pwdata,
    output logic [cbp_pkg::APB_W-1:0]  prdata,
    output logic        pready
);

    localparam int GW    = cbp_pkg::GAIN_W;
    localparam int DW    = cbp_pkg::DATA_W;
    localparam int OW    = cbp_pkg::OUT_W;
    localparam int IW    = cbp_pkg::INT_W;
    localparam int ZW    = cbp_pkg::DZ_W;
    localparam int E_W   = DW + 1;
    localparam int EA_W  = DW + 2;
    localparam int OP_W  = DW + 3;
    localparam int P_W   = GW + OP_W;
    localparam int S_W   = P_W + 1;
    localparam int V_W   = S_W - cbp_pkg::FRAC;
    localparam int VD_W  = V_W + 2;

    // configuration
    logic signed [GW-1:0] r_speed_kp, r_speed_ki, r_angle_kp, r_angle_kd;
    logic signed [GW-1:0] r_gyro_kp, r_gyro_kd, r_zero_ofs;
    logic        [ZW-1:0] r_dead_zone;
    logic                 w_cfg_wr;
    logic [2:0]           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[cbp_pkg::ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_kp  <= '0;
            r_speed_ki  <= '0;
            r_angle_kp  <= '0;
            r_angle_kd  <= '0;
            r_gyro_kp   <= '0;
            r_gyro_kd   <= '0;
            r_zero_ofs  <= '0;
            r_dead_zone <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                cbp_pkg::REG_SPEED_KP:  r_speed_kp  <= pwdata[GW-1:0];
                cbp_pkg::REG_SPEED_KI:  r_speed_ki  <= pwdata[GW-1:0];
                cbp_pkg::REG_ANGLE_KP:  r_angle_kp  <= pwdata[GW-1:0];
                cbp_pkg::REG_ANGLE_KD:  r_angle_kd  <= pwdata[GW-1:0];
                cbp_pkg::REG_GYRO_KP:   r_gyro_kp   <= pwdata[GW-1:0];
                cbp_pkg::REG_GYRO_KD:   r_gyro_kd   <= pwdata[GW-1:0];
                cbp_pkg::REG_ZERO_OFS:  r_zero_ofs  <= pwdata[GW-1:0];
                cbp_pkg::REG_DEAD_ZONE: r_dead_zone <= pwdata[ZW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_cfg_idx)
            cbp_pkg::REG_SPEED_KP:  prdata[GW-1:0] = r_speed_kp;
            cbp_pkg::REG_SPEED_KI:  prdata[GW-1:0] = r_speed_ki;
            cbp_pkg::REG_ANGLE_KP:  prdata[GW-1:0] = r_angle_kp;
            cbp_pkg::REG_ANGLE_KD:  prdata[GW-1:0] = r_angle_kd;
            cbp_pkg::REG_GYRO_KP:   prdata[GW-1:0] = r_gyro_kp;
            cbp_pkg::REG_GYRO_KD:   prdata[GW-1:0] = r_gyro_kd;
            cbp_pkg::REG_ZERO_OFS:  prdata[GW-1:0] = r_zero_ofs;
            cbp_pkg::REG_DEAD_ZONE: prdata[ZW-1:0] = r_dead_zone;
            default: prdata = '0;
        endcase
    end

    // input stage
    logic                 r_in_vld;
    logic [1:0]           r_in_mode;
    logic signed [DW-1:0] r_in_ref, r_in_meas;
    logic                 r_out_vld;
    logic [1:0]           r_out_mode;
    logic signed [OW-1:0] r_out_val;
    logic                 w_move;

    assign w_move     = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode <= i_s_tuser;
            r_in_ref  <= i_s_tdata[DW-1:0];
            r_in_meas <= i_s_tdata[2*DW-1:DW];
        end
    end

    // loop state
    logic signed [IW-1:0]   r_spd_int;
    logic signed [EA_W-1:0] r_ang_last;
    logic signed [E_W-1:0]  r_gyr_last;

    // datapath
    logic signed [E_W-1:0]  w_e;
    logic signed [EA_W-1:0] w_e_ang;
    logic signed [EA_W-1:0] w_int_sum;
    logic signed [IW-1:0]   w_int_new;
    logic signed [OP_W-1:0] w_d_ang;
    logic signed [EA_W-1:0] w_d_gyr;
    logic signed [OP_W-1:0] w_x, w_y;
    logic signed [GW-1:0]   w_ga, w_gb;
    logic signed [P_W-1:0]  w_pa, w_pb;
    logic signed [S_W-1:0]  w_sum;
    logic signed [V_W-1:0]  w_v;
    logic signed [VD_W-1:0] w_vx, w_vdz;
    logic signed [OW-1:0]   w_res;

    function automatic logic signed [OW-1:0] f_clamp(
        input logic signed [VD_W-1:0] x,
        input logic signed [OW-1:0]   lim
    );
        logic signed [VD_W-1:0] l;
        l = VD_W'(lim);
        if (x > l) return lim;
        else if (x < -l) return -lim;
        else return x[OW-1:0];
    endfunction

    always_comb begin
        w_e       = E_W'(r_in_ref) - E_W'(r_in_meas);
        w_e_ang   = EA_W'(r_zero_ofs) - EA_W'(r_in_ref) - EA_W'(r_in_meas);
        w_int_sum = EA_W'(r_spd_int) + EA_W'(w_e);
        if (w_int_sum > EA_W'(cbp_pkg::SPEED_INT_LIMIT)) begin
            w_int_new = cbp_pkg::SPEED_INT_LIMIT;
        end else if (w_int_sum < -EA_W'(cbp_pkg::SPEED_INT_LIMIT)) begin
            w_int_new = -cbp_pkg::SPEED_INT_LIMIT;
        end else begin
            w_int_new = w_int_sum[IW-1:0];
        end
        w_d_ang = OP_W'(w_e_ang) - OP_W'(r_ang_last);
        w_d_gyr = EA_W'(w_e) - EA_W'(r_gyr_last);

        unique case (r_in_mode)
            cbp_pkg::MODE_SPEED: begin
                w_ga = r_speed_kp;
                w_gb = r_speed_ki;
                w_x  = OP_W'(w_e);
                w_y  = OP_W'(w_int_new);
            end
            cbp_pkg::MODE_ANGLE: begin
                w_ga = r_angle_kp;
                w_gb = r_angle_kd;
                w_x  = OP_W'(w_e_ang);
                w_y  = w_d_ang;
            end
            default: begin
                w_ga = r_gyro_kp;
                w_gb = r_gyro_kd;
                w_x  = OP_W'(w_e);
                w_y  = OP_W'(w_d_gyr);
            end
        endcase

        w_pa  = P_W'(w_ga) * P_W'(w_x);
        w_pb  = P_W'(w_gb) * P_W'(w_y);
        w_sum = S_W'(w_pa) + S_W'(w_pb);
        w_v   = w_sum[S_W-1:cbp_pkg::FRAC];
        w_vx  = VD_W'(w_v);

        if (w_v > 0) begin
            w_vdz = w_vx + $signed(VD_W'(r_dead_zone));
        end else if (w_v < 0) begin
            w_vdz = w_vx - $signed(VD_W'(r_dead_zone));
        end else begin
            w_vdz = w_vx;
        end

        unique case (r_in_mode)
            cbp_pkg::MODE_SPEED: w_res = f_clamp(w_vx, cbp_pkg::SPEED_OUT_LIMIT);
            cbp_pkg::MODE_ANGLE: w_res = -f_clamp(w_vx, cbp_pkg::ANGLE_OUT_LIMIT);
            cbp_pkg::MODE_GYRO:  w_res = f_clamp(w_vdz, cbp_pkg::GYRO_OUT_LIMIT);
            default:             w_res = '0;
        endcase
    end

    // commit loop state as the item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_int  <= '0;
            r_ang_last <= '0;
            r_gyr_last <= '0;
        end else if (w_move) begin
            unique case (r_in_mode)
                cbp_pkg::MODE_SPEED: r_spd_int  <= w_int_new;
                cbp_pkg::MODE_ANGLE: r_ang_last <= w_e_ang;
                cbp_pkg::MODE_GYRO:  r_gyr_last <= w_e;
                default: ;
            endcase
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_move) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_mode <= r_in_mode;
            r_out_val  <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_mode;
    assign o_m_tdata  = {{(16-OW){1'b0}}, r_out_val};

    `CBP_ASSERT(a_int_bound,
        (r_spd_int <= cbp_pkg::SPEED_INT_LIMIT) && (r_spd_int >= -cbp_pkg::SPEED_INT_LIMIT),
        "speed integral outside its limit")
    `CBP_ASSERT_NEXT(a_state_hold, !w_move,
        $stable(r_spd_int) && $stable(r_ang_last) && $stable(r_gyr_last),
        "loop state changed without an item")
    `CBP_ASSERT(a_unused_zero,
        !(o_m_tvalid && (o_m_tuser == cbp_pkg::MODE_UNUSED)) || (o_m_tdata == '0),
        "unused mode gave a nonzero result")
    `CBP_ASSERT_NEXT(a_move_out, w_move, o_m_tvalid,
        "item lost between stages")

endmodule
